### rtl/core/dtsb_pkg.sv
`default_nettype none
package dtsb_pkg;

  localparam int COLUMNS      = 565;
  localparam int ROWS_SCANNED = 430;
  localparam int BIN_WIDTH    = 11;
  localparam int BINS         = 51;

  localparam int COL_AW    = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS_SCANNED + 1);
  localparam int SWEEP_LEN = (COLUMNS > BINS * BIN_WIDTH) ? COLUMNS : BINS * BIN_WIDTH;
  localparam int SWEEP_W   = $clog2(SWEEP_LEN + 1);
  localparam int LANE_W    = (BIN_WIDTH > 1) ? $clog2(BIN_WIDTH) : 1;

  localparam int DEPTH_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE       = 2'd2;

  localparam logic [15:0]        DIFF_THRESHOLD_RST  = 16'd100;
  localparam logic [DEPTH_W-1:0] MIN_VALID_DEPTH_RST = 12'd5;
  localparam logic [DEPTH_W-1:0] MAX_RANGE_RST       = 12'd3000;

  // floor(x / 20) for 12-bit x as (x * ceil(2^16 / 20)) >> 16
  localparam int RANGE_DIV   = 20;
  localparam int RECIP_SHIFT = 16;
  localparam int RANGE_RECIP = ((1 << RECIP_SHIFT) + RANGE_DIV - 1) / RANGE_DIV;
  localparam int PROD_W      = DEPTH_W + RECIP_SHIFT;

  localparam logic [7:0] NO_RETURN_LIMIT = 8'd150;
  localparam logic [7:0] NO_RETURN_CODE  = 8'd1;

  typedef struct packed {
    logic [15:0] depth_sample;
    logic [15:0] template_depth;
    logic        end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [5:0] bin_index;
    logic [7:0] range_value;
    logic       last_bin;
  } scan_t;

  typedef struct packed {
    logic accept;
    logic pix_update;
    logic init_clear;
    logic bin_read;
    logic bin_fold;
    logic emit;
    logic tail_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic eof;
    logic lane_last;
    logic bin_last;
    logic in_cols;
    logic last_col;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/dtsb_ram.sv
`default_nettype none
module dtsb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 565
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/dtsb_ctrl.sv
`default_nettype none
module dtsb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pixel_valid,
  output logic                     pixel_stall,
  input  wire dtsb_pkg::dp_status_t status,
  output dtsb_pkg::dp_cmd_t        cmd
);
  import dtsb_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PIX  = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BACC = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign pixel_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_clear = 1'b1;
        if (status.last_col) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        cmd.pix_update = 1'b1;
        state_next     = status.eof ? S_BRD : S_IDLE;
      end
      S_BRD: begin
        cmd.bin_read = 1'b1;
        state_next   = S_BACC;
      end
      S_BACC: begin
        cmd.bin_fold = 1'b1;
        state_next   = status.lane_last ? S_EMIT : S_BRD;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!status.bin_last) begin
            state_next = S_BRD;
          end else if (status.in_cols) begin
            state_next = S_CLR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CLR: begin
        cmd.tail_clear = 1'b1;
        if (status.last_col) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/dtsb_datapath.sv
`default_nettype none
module dtsb_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [dtsb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dtsb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire dtsb_pkg::pixel_t                      pixel,
  output logic                                       scan_valid,
  input  wire logic                                  scan_stall,
  output dtsb_pkg::scan_t                            scan,
  input  wire dtsb_pkg::dp_cmd_t                     cmd,
  output dtsb_pkg::dp_status_t                       status
);
  import dtsb_pkg::*;

  logic [15:0]        diff_threshold;
  logic [DEPTH_W-1:0] min_valid_depth;
  logic [DEPTH_W-1:0] max_range;

  pixel_t             pix_q;
  logic [COL_AW-1:0]  column_position;
  logic [ROW_W-1:0]   row_position;
  logic [SWEEP_W-1:0] sweep;
  logic [LANE_W-1:0]  lane;
  logic [5:0]         bin_cnt;
  logic [DEPTH_W-1:0] acc;
  logic               any_col;
  logic               incl_q;

  logic               ram_we;
  logic [COL_AW-1:0]  ram_wr_addr;
  logic [DEPTH_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [COL_AW-1:0]  ram_rd_addr;
  logic [DEPTH_W-1:0] ram_rd_data;

  logic [16:0]        diff;
  logic               hit;
  logic               in_cols;
  logic [PROD_W-1:0]  prod;
  logic [7:0]         quot;
  logic [7:0]         range_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold  <= DIFF_THRESHOLD_RST;
      min_valid_depth <= MIN_VALID_DEPTH_RST;
      max_range       <= MAX_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_THRESHOLD:  diff_threshold  <= cfg_data;
        REG_MIN_VALID_DEPTH: min_valid_depth <= cfg_data[DEPTH_W-1:0];
        REG_MAX_RANGE:       max_range       <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_cols = (sweep < SWEEP_W'(COLUMNS));

  // obstacle test: template - depth taken signed
  assign diff = {1'b0, pix_q.template_depth} - {1'b0, pix_q.depth_sample};
  assign hit  = (row_position < ROW_W'(ROWS_SCANNED))
              && !diff[16] && (diff[15:0] > diff_threshold)
              && (pix_q.depth_sample > {4'd0, min_valid_depth})
              && (pix_q.depth_sample < {4'd0, ram_rd_data});

  assign ram_rd_en   = cmd.accept | cmd.bin_read;
  assign ram_rd_addr = cmd.accept ? column_position : sweep[COL_AW-1:0];
  assign ram_we      = (cmd.pix_update & hit) | cmd.init_clear | cmd.tail_clear
                     | (cmd.bin_read & in_cols);
  assign ram_wr_addr = cmd.pix_update ? column_position : sweep[COL_AW-1:0];
  assign ram_wr_data = cmd.init_clear ? MAX_RANGE_RST
                     : cmd.pix_update ? pix_q.depth_sample[DEPTH_W-1:0]
                     : max_range;

  dtsb_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (COLUMNS)
  ) u_column_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_q <= pixel;
    end
    if (cmd.bin_read) begin
      incl_q <= in_cols;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      sweep           <= '0;
      lane            <= '0;
      bin_cnt         <= '0;
      acc             <= MAX_RANGE_RST;
      any_col         <= 1'b0;
    end else begin
      if (cmd.pix_update) begin
        if (pix_q.end_of_frame) begin
          column_position <= '0;
          row_position    <= '0;
          sweep           <= '0;
          lane            <= '0;
          bin_cnt         <= '0;
          acc             <= max_range;
          any_col         <= 1'b0;
        end else if (column_position == COL_AW'(COLUMNS - 1)) begin
          column_position <= '0;
          if (row_position < ROW_W'(ROWS_SCANNED)) begin
            row_position <= row_position + 1'b1;
          end
        end else begin
          column_position <= column_position + 1'b1;
        end
      end
      if (cmd.init_clear | cmd.tail_clear) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.bin_fold) begin
        sweep <= sweep + 1'b1;
        lane  <= lane + 1'b1;
        if (incl_q && (!any_col || ram_rd_data < acc)) begin
          acc     <= ram_rd_data;
          any_col <= 1'b1;
        end
      end
      if (cmd.emit) begin
        lane    <= '0;
        bin_cnt <= bin_cnt + 1'b1;
        acc     <= max_range;
        any_col <= 1'b0;
      end
    end
  end

  assign prod      = PROD_W'(acc) * PROD_W'(RANGE_RECIP);
  assign quot      = prod[RECIP_SHIFT+7:RECIP_SHIFT];
  assign range_val = (quot >= NO_RETURN_LIMIT) ? NO_RETURN_CODE : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (cmd.emit) begin
      scan_valid <= 1'b1;
    end else if (!scan_stall) begin
      scan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      scan.bin_index   <= bin_cnt;
      scan.range_value <= range_val;
      scan.last_bin    <= (bin_cnt == 6'(BINS - 1));
    end
  end

  assign status.eof       = pix_q.end_of_frame;
  assign status.lane_last = (lane == LANE_W'(BIN_WIDTH - 1));
  assign status.bin_last  = (bin_cnt == 6'(BINS - 1));
  assign status.in_cols   = in_cols;
  assign status.last_col  = (sweep == SWEEP_W'(COLUMNS - 1));
  assign status.out_free  = !scan_valid || !scan_stall;

endmodule
`default_nettype wire

### rtl/core/depth_to_scan_binner_top.sv
// Depth frame to scan-line binner.
// pixel channel: depth and template pixels in row-major order, end_of_frame on
// the last pixel; a transfer happens when pixel_valid is high and pixel_stall low.
// scan channel: one result per bin (bin_index, range_value, last_bin), BINS per frame.
// cfg port: cfg_we with cfg_index 0..2 writes diff_threshold, min_valid_depth,
// max_range; write only while the block is idle.
// Pixels do not overlap: each pixel finishes its read-modify-write of the
// single-write-port column RAM before the next pixel is taken.
// Frame end: for each bin the controller reads the bin's columns one by one
// from the column RAM and folds each into the bin minimum, then emits the
// result; after the last bin the columns past it are reset in the column store.
// The first result is registered once the first bin's columns are folded.
// Reset: registers return to defaults and a clearing pass over all COLUMNS (565)
// columns writes the start value into the column RAM; pixel_stall stays high.
// A stall on the scan channel holds the result register and pauses the scan;
// pixel transfers resume once the last bin is in the output register and the
// columns past the last bin are cleared.
`default_nettype none
module depth_to_scan_binner_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dtsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_stall,
  input  wire dtsb_pkg::pixel_t                pixel,
  output logic                                 scan_valid,
  input  wire logic                            scan_stall,
  output dtsb_pkg::scan_t                      scan
);
  import dtsb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dtsb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  dtsb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .scan       (scan),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

### rtl/core/dtsb_checker.sv
`default_nettype none
module dtsb_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            pixel_valid,
  input wire logic            pixel_stall,
  input wire dtsb_pkg::pixel_t pixel,
  input wire logic            scan_valid,
  input wire logic            scan_stall,
  input wire dtsb_pkg::scan_t scan
);
  import dtsb_pkg::*;

  // held result stays put
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    scan_valid && scan_stall |=> scan_valid && $stable(scan))
    else $error("scan result changed while stalled");

  // reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !scan_valid && pixel_stall)
    else $error("block not quiet after reset");

  // no pixel transfer while bins of the frame remain
  a_no_pixel_mid_scan: assert property (@(posedge clk) disable iff (rst)
    scan_valid && !scan.last_bin |-> pixel_stall)
    else $error("pixel taken during scan output");

  // a pixel without end_of_frame causes no result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !pixel.end_of_frame && !scan_valid |=> !scan_valid)
    else $error("result without end of frame");

endmodule

bind depth_to_scan_binner_top dtsb_checker u_dtsb_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel),
  .scan_valid  (scan_valid),
  .scan_stall  (scan_stall),
  .scan        (scan)
);
`default_nettype wire
